// ===== hw/rtl/rdmq_pkg.sv =====
// Package for the ring deque message queue.
// Holds sizes, the action codes and the structs shared by the control and top files.
// No dependencies.
package rdmq_pkg;

    localparam int DEPTH     = 16;
    localparam int MSG_WIDTH = 32;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ACT_SEND   = 2'd0,
        ACT_URGENT = 2'd1,
        ACT_RECV   = 2'd2,
        ACT_PEEK   = 2'd3
    } t_action;

    // Memory request issued by the control unit in the cycle a word is accepted.
    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
    } t_mem_req;

    // Outcome of one action, captured in the result stage.
    typedef struct packed {
        logic             ok;
        logic             rd;
        logic [CNT_W-1:0] free;
    } t_ctrl_res;

endpackage

// ===== hw/rtl/rdmq_if.sv =====
// Channel interfaces of the ring deque message queue: request and response.
// Depends on rdmq_pkg for the field widths.
interface rdmq_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    action;
    logic [rdmq_pkg::MSG_WIDTH-1:0] message_in;

    modport source (output valid, output action, output message_in, input ready);
    modport sink   (input valid, input action, input message_in, output ready);
endinterface

interface rdmq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          ok;
    logic [rdmq_pkg::MSG_WIDTH-1:0] message_out;
    logic [rdmq_pkg::CNT_W-1:0]     free_count;

    modport source (output valid, output ok, output message_out, output free_count,
                    input ready);
    modport sink   (input valid, input ok, input message_out, input free_count,
                    output ready);
endinterface

// ===== hw/rtl/rdmq_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module rdmq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_addr,
    input  logic [WIDTH-1:0]                 i_wdata,
    output logic [WIDTH-1:0]                 o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/rdmq_ctrl.sv =====
// Pointer and occupancy control of the ring deque message queue.
// Depends on rdmq_pkg; drives the memory request and the per-word outcome.
module rdmq_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [rdmq_pkg::CNT_W-1:0] i_cfg_data,
    input  logic                    i_accept,
    input  logic [1:0]              i_action,
    output rdmq_pkg::t_mem_req      o_mem,
    output rdmq_pkg::t_ctrl_res     o_res
);
    import rdmq_pkg::*;

    logic [CNT_W-1:0]  r_qlen, n_qlen;
    logic [CNT_W-1:0]  r_free, n_free;
    logic [ADDR_W-1:0] r_head, n_head;
    logic [ADDR_W-1:0] r_tail, n_tail;

    logic [CNT_W-1:0]  tail_inc;
    logic [CNT_W-1:0]  head_inc;
    logic [ADDR_W-1:0] head_dec;
    logic [CNT_W-1:0]  cfg_len;
    logic              full;
    logic              empty;

    assign full  = (r_free == '0);
    assign empty = (r_free == r_qlen);

    assign tail_inc = CNT_W'(r_tail) + CNT_W'(1);
    assign head_inc = CNT_W'(r_head) + CNT_W'(1);
    assign head_dec = (r_head == '0) ? ADDR_W'(r_qlen - CNT_W'(1))
                                     : r_head - ADDR_W'(1);

    // Length of zero is taken as one, anything above the store size saturates.
    always_comb begin
        cfg_len = i_cfg_data;
        if (cfg_len == '0) begin
            cfg_len = CNT_W'(1);
        end else if (cfg_len > CNT_W'(DEPTH)) begin
            cfg_len = CNT_W'(DEPTH);
        end
    end

    always_comb begin
        n_qlen     = r_qlen;
        n_free     = r_free;
        n_head     = r_head;
        n_tail     = r_tail;
        o_mem.we   = 1'b0;
        o_mem.re   = 1'b0;
        o_mem.addr = r_head;
        o_res.ok   = 1'b0;
        o_res.rd   = 1'b0;
        if (i_cfg_we) begin
            n_qlen = cfg_len;
            n_free = cfg_len;
            n_head = '0;
            n_tail = '0;
        end else if (i_accept) begin
            case (t_action'(i_action))
                ACT_SEND: begin
                    if (!full) begin
                        o_mem.we   = 1'b1;
                        o_mem.addr = r_tail;
                        n_tail     = (tail_inc >= r_qlen) ? '0 : tail_inc[ADDR_W-1:0];
                        n_free     = r_free - CNT_W'(1);
                        o_res.ok   = 1'b1;
                    end
                end
                ACT_URGENT: begin
                    if (!full) begin
                        o_mem.we   = 1'b1;
                        o_mem.addr = head_dec;
                        n_head     = head_dec;
                        n_free     = r_free - CNT_W'(1);
                        o_res.ok   = 1'b1;
                    end
                end
                ACT_RECV, ACT_PEEK: begin
                    if (!empty) begin
                        o_mem.re = 1'b1;
                        o_res.ok = 1'b1;
                        o_res.rd = 1'b1;
                        if (t_action'(i_action) == ACT_RECV) begin
                            n_head = (head_inc >= r_qlen) ? '0 : head_inc[ADDR_W-1:0];
                            n_free = r_free + CNT_W'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        o_res.free = n_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlen <= CNT_W'(DEPTH);
            r_free <= CNT_W'(DEPTH);
            r_head <= '0;
            r_tail <= '0;
        end else begin
            r_qlen <= n_qlen;
            r_free <= n_free;
            r_head <= n_head;
            r_tail <= n_tail;
        end
    end
endmodule

// ===== hw/rtl/ring_deque_message_queue.sv =====
// Top level of the ring deque message queue.
// Depends on rdmq_pkg, rdmq_if, rdmq_ram and rdmq_ctrl.
//
// A circular queue of 32-bit message words that takes one action per request word:
// send appends at the tail, urgent send inserts before the head, receive pops the
// head and peek reads the head in place. Every request gives exactly one response
// word carrying ok, the head message for a successful receive or peek (zero
// otherwise) and the number of free slots after the action. A send to a full queue
// or a receive or peek on an empty one is refused with ok low and changes nothing;
// the requester simply retries. The length in use (1 to 16, reset 16) is written
// through the configuration port, which also empties the queue; write it only while
// no response is outstanding. The messages live in a single-port RAM with a
// registered read. Pointers and the free count are updated in the cycle a request
// word is accepted, so the response follows in the next cycle, and a new request
// can be taken every cycle while the response is not stalled: the rate is one word
// per clock, set by the one RAM access each word needs. A stalled response holds
// the result stage and the RAM read register, and the request side then waits.
module ring_deque_message_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    rdmq_req_if.sink                   i_req,
    rdmq_rsp_if.source                 o_rsp,
    input  logic                       i_cfg_we,
    input  logic [rdmq_pkg::CNT_W-1:0] i_cfg_data
);
    import rdmq_pkg::*;

    t_mem_req             mem_req;
    t_ctrl_res            ctrl_res;
    logic                 accept;
    logic [MSG_WIDTH-1:0] rdata;

    logic             r_s1_valid, n_s1_valid;
    logic             r_s1_ok;
    logic             r_s1_rd;
    logic [CNT_W-1:0] r_s1_free;

    // The result stage frees up when its word is taken, so requests keep flowing.
    assign i_req.ready = !r_s1_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    rdmq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_action   (i_req.action),
        .o_mem      (mem_req),
        .o_res      (ctrl_res)
    );

    // The RAM read register only loads on a read, so it holds through a stall.
    rdmq_ram #(
        .WIDTH (MSG_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_re    (mem_req.re),
        .i_addr  (mem_req.addr),
        .i_wdata (i_req.message_in),
        .o_rdata (rdata)
    );

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (accept) begin
            n_s1_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ok   <= ctrl_res.ok;
            r_s1_rd   <= ctrl_res.rd;
            r_s1_free <= ctrl_res.free;
        end
    end

    assign o_rsp.valid       = r_s1_valid;
    assign o_rsp.ok          = r_s1_ok;
    assign o_rsp.message_out = r_s1_rd ? rdata : '0;
    assign o_rsp.free_count  = r_s1_free;

    // A RAM read or write only happens for an accepted request word.
    a_mem_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_req.we || mem_req.re) |-> accept)
        else $error("memory access without an accepted request");

    // Reading and writing in one cycle would mean two actions at once.
    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_req.we && mem_req.re))
        else $error("read and write in the same cycle");

    // The free count reported never exceeds the store size.
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (r_s1_free <= CNT_W'(DEPTH)))
        else $error("free count above store size");

    // A read result held in a stall must not be disturbed by the RAM.
    a_read_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_rd && !o_rsp.ready) |=> (rdata == $past(rdata)))
        else $error("read data changed while the response was stalled");
endmodule

// ===== tb/ring_deque_message_queue_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ring_deque_message_queue: a scripted opening and random traffic.
// Uses rdmq_pkg, the rdmq_req_if / rdmq_rsp_if channel interfaces and the ring_deque_message_queue top.
module ring_deque_message_queue_test;
    import rdmq_pkg::*;

    // Random words after the scripted opening, split into phases with one length each.
    localparam int PHASES          = 12;
    localparam int WORDS_PER_PHASE = 127;
    // The receiver holds off this long once, so the request side has to back up.
    localparam int HOLD_CYCLES     = 64;
    // Upper bound on the wait for outstanding responses before a register write.
    localparam int DRAIN_GUARD     = 5000;
    localparam int SCRIPT_ROWS     = 29;

    // One response word as the queue should produce it.
    typedef struct packed {
        logic                 ok;
        logic [MSG_WIDTH-1:0] data;
        logic [CNT_W-1:0]     free;
    } t_reply;

    // A row of the opening script is either a length write or a request word.
    // When fixed is set, the expected response is the one typed into the row.
    typedef struct packed {
        logic                 is_cfg;
        logic [CNT_W-1:0]     length;
        t_action              act;
        logic [MSG_WIDTH-1:0] msg;
        logic                 fixed;
        logic                 ok;
        logic [MSG_WIDTH-1:0] data;
        logic [CNT_W-1:0]     free;
    } t_script_row;

    // Carried alongside each request word so the checker knows whether a typed
    // response replaces the computed one.
    typedef struct packed {
        logic   fixed;
        t_reply reply;
    } t_typed_reply;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CNT_W-1:0] i_cfg_data;

    rdmq_req_if req_ch();
    rdmq_rsp_if rsp_ch();

    ring_deque_message_queue DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow copy of the queue: the store, both ends, the free count and the length in use.
    logic [MSG_WIDTH-1:0] shadow_store [DEPTH];
    int shadow_head;
    int shadow_tail;
    int shadow_free;
    int shadow_len;

    t_reply       expected_replies [$];
    t_typed_reply typed_replies [$];

    int mismatches;
    int words_by_action [4];
    int refused_words;
    int full_hits;
    int lengths_written;

    // Traffic shaping shared by the sender (main process) and the receiver process.
    logic steady_run;
    int   holds_requested;
    int   holds_done;

    // Scripted opening. Rows with an obvious answer carry it; the rest are checked
    // against the shadow queue like the random traffic.
    t_script_row opening_script [SCRIPT_ROWS] = '{
        // Empty after reset: peek and receive are refused, all sixteen slots free.
        '{1'b0, 5'd0,  ACT_PEEK,   32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 5'd16},
        '{1'b0, 5'd0,  ACT_RECV,   32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000, 5'd16},
        // Extremes of the message word, then an urgent word that jumps the line.
        '{1'b0, 5'd0,  ACT_SEND,   32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 5'd15},
        '{1'b0, 5'd0,  ACT_SEND,   32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000, 5'd14},
        '{1'b0, 5'd0,  ACT_URGENT, 32'hA5A5_A5A5, 1'b1, 1'b1, 32'h0000_0000, 5'd13},
        '{1'b0, 5'd0,  ACT_PEEK,   32'h0000_0000, 1'b1, 1'b1, 32'hA5A5_A5A5, 5'd13},
        '{1'b0, 5'd0,  ACT_RECV,   32'h0000_0000, 1'b1, 1'b1, 32'hA5A5_A5A5, 5'd14},
        '{1'b0, 5'd0,  ACT_RECV,   32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 5'd15},
        '{1'b0, 5'd0,  ACT_RECV,   32'h5555_5555, 1'b1, 1'b1, 32'hFFFF_FFFF, 5'd16},
        // A length of zero is taken as one slot, so the queue is full after one send.
        '{1'b1, 5'd0,  ACT_SEND,   32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 5'd0},
        '{1'b0, 5'd0,  ACT_SEND,   32'h5A5A_5A5A, 1'b1, 1'b1, 32'h0000_0000, 5'd0},
        '{1'b0, 5'd0,  ACT_SEND,   32'h1234_5678, 1'b1, 1'b0, 32'h0000_0000, 5'd0},
        '{1'b0, 5'd0,  ACT_URGENT, 32'h0000_0001, 1'b1, 1'b0, 32'h0000_0000, 5'd0},
        '{1'b0, 5'd0,  ACT_PEEK,   32'h0000_0000, 1'b1, 1'b1, 32'h5A5A_5A5A, 5'd0},
        '{1'b0, 5'd0,  ACT_RECV,   32'h0000_0000, 1'b1, 1'b1, 32'h5A5A_5A5A, 5'd1},
        '{1'b0, 5'd0,  ACT_URGENT, 32'h8000_0000, 1'b1, 1'b1, 32'h0000_0000, 5'd0},
        '{1'b0, 5'd0,  ACT_RECV,   32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000, 5'd1},
        // A length above the depth saturates; the urgent word wraps the head backwards.
        '{1'b1, 5'd31, ACT_SEND,   32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 5'd0},
        '{1'b0, 5'd0,  ACT_URGENT, 32'hDEAD_BEEF, 1'b0, 1'b0, 32'h0000_0000, 5'd0},
        '{1'b0, 5'd0,  ACT_SEND,   32'h0F0F_0F0F, 1'b0, 1'b0, 32'h0000_0000, 5'd0},
        '{1'b0, 5'd0,  ACT_RECV,   32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 5'd0},
        // A length write drops the word still queued.
        '{1'b1, 5'd17, ACT_SEND,   32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 5'd0},
        '{1'b0, 5'd0,  ACT_PEEK,   32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000, 5'd16},
        // Short queue of three: mixed ends until a send is refused.
        '{1'b1, 5'd3,  ACT_SEND,   32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 5'd0},
        '{1'b0, 5'd0,  ACT_SEND,   32'h1357_9BDF, 1'b0, 1'b0, 32'h0000_0000, 5'd0},
        '{1'b0, 5'd0,  ACT_URGENT, 32'h2468_ACE0, 1'b0, 1'b0, 32'h0000_0000, 5'd0},
        '{1'b0, 5'd0,  ACT_SEND,   32'h7654_3210, 1'b0, 1'b0, 32'h0000_0000, 5'd0},
        '{1'b0, 5'd0,  ACT_SEND,   32'hFEDC_BA98, 1'b0, 1'b0, 32'h0000_0000, 5'd0},
        '{1'b0, 5'd0,  ACT_RECV,   32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 5'd0}
    };

    // 100 MHz clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the queue stops answering.
    initial begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // A length write clamps the value to 1..DEPTH and empties the queue.
    function automatic void load_length(input logic [CNT_W-1:0] value);
        int v;
        v = int'(value);
        if (v == 0) begin
            v = 1;
        end
        if (v > DEPTH) begin
            v = DEPTH;
        end
        shadow_len  = v;
        shadow_head = 0;
        shadow_tail = 0;
        shadow_free = v;
    endfunction

    // Applies one request word to the shadow queue and returns the response it
    // must produce. Refused words leave the shadow state alone.
    function automatic t_reply apply_action(input t_action act, input logic [MSG_WIDTH-1:0] msg);
        t_reply r;
        r = '0;
        case (act)
            ACT_SEND: begin
                if (shadow_free != 0) begin
                    shadow_store[shadow_tail] = msg;
                    shadow_tail = (shadow_tail + 1 >= shadow_len) ? 0 : shadow_tail + 1;
                    shadow_free--;
                    r.ok = 1'b1;
                end
            end
            ACT_URGENT: begin
                if (shadow_free != 0) begin
                    // The head steps back one slot, wrapping to the last slot in use.
                    shadow_head = ((shadow_head == 0) ? shadow_len : shadow_head) - 1;
                    shadow_store[shadow_head] = msg;
                    shadow_free--;
                    r.ok = 1'b1;
                end
            end
            default: begin
                // Receive and peek both need at least one queued word.
                if (shadow_free < shadow_len) begin
                    r.data = shadow_store[shadow_head];
                    r.ok   = 1'b1;
                    if (act == ACT_RECV) begin
                        shadow_head = (shadow_head + 1 >= shadow_len) ? 0 : shadow_head + 1;
                        shadow_free++;
                    end
                end
            end
        endcase
        r.free = CNT_W'(shadow_free);
        return r;
    endfunction

    function automatic void note_mismatch(input string what, input t_reply want, input t_reply got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s: expected ok=%0d msg=%h free=%0d, got ok=%0d msg=%h free=%0d",
                     $realtime, what, want.ok, want.data, want.free, got.ok, got.data, got.free);
        end
    endfunction

    // Checker. Everything is sampled at the rising edge, before the queue's own
    // updates for that edge land. A word accepted at this edge is predicted before
    // the response check, so the oldest expectation is always the right one even
    // if the response came back with no delay at all.
    always @(posedge i_clk) begin : scoreboard
        t_reply       predicted;
        t_reply       observed;
        t_typed_reply typed;
        if (!i_rst_n) begin
            shadow_len  = (DEPTH < 16) ? DEPTH : 16;
            shadow_head = 0;
            shadow_tail = 0;
            shadow_free = shadow_len;
        end else begin
            if (i_cfg_we) begin
                load_length(i_cfg_data);
            end
            if (req_ch.valid && req_ch.ready) begin
                predicted = apply_action(t_action'(req_ch.action), req_ch.message_in);
                if (typed_replies.size() != 0) begin
                    typed = typed_replies.pop_front();
                    if (typed.fixed) begin
                        predicted = typed.reply;
                    end
                end
                expected_replies.push_back(predicted);
                words_by_action[req_ch.action]++;
                if (!predicted.ok) begin
                    refused_words++;
                end else if (predicted.free == 0 &&
                             (req_ch.action == ACT_SEND || req_ch.action == ACT_URGENT)) begin
                    full_hits++;
                end
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                observed.ok   = rsp_ch.ok;
                observed.data = rsp_ch.message_out;
                observed.free = rsp_ch.free_count;
                if (expected_replies.size() == 0) begin
                    note_mismatch("response word with nothing outstanding", '0, observed);
                end else begin
                    predicted = expected_replies.pop_front();
                    if (observed.ok !== predicted.ok || observed.data !== predicted.data ||
                        observed.free !== predicted.free) begin
                        note_mismatch("response word differs", predicted, observed);
                    end
                end
            end
        end
    end

    // Receiver. Normally it stalls about one cycle in six; during a steady phase it
    // never stalls. When the sender asks for a hold-off, ready stays low for a fixed
    // number of cycles counted here, which backs the request channel up.
    initial begin : receiver
        int hold_count;
        rsp_ch.ready <= 1'b0;
        holds_done   <= 0;
        forever begin
            @(posedge i_clk);
            if (holds_requested > holds_done) begin
                rsp_ch.ready <= 1'b0;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) begin
                    @(posedge i_clk);
                end
                holds_done <= holds_done + 1;
            end else begin
                rsp_ch.ready <= steady_run || ($urandom_range(99) >= 16);
            end
        end
    end

    // Offers one request word and returns at the edge where it is taken. Before
    // the word the sender may idle at random, unless a steady phase is on.
    task automatic offer_word(input t_action act, input logic [MSG_WIDTH-1:0] msg,
                              input logic fixed, input t_reply reply);
        while (!steady_run && $urandom_range(99) < 16) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        typed_replies.push_back(t_typed_reply'{fixed, reply});
        req_ch.valid      <= 1'b1;
        req_ch.action     <= act;
        req_ch.message_in <= msg;
        @(posedge i_clk);
        while (!req_ch.ready) begin
            @(posedge i_clk);
        end
    endtask

    // Stops offering and waits until every response is back, then lets the result
    // stage settle. Polled on the falling edge so the checker has already recorded
    // the word of the last rising edge.
    task automatic settle_queue();
        int guard;
        guard = 0;
        req_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (expected_replies.size() != 0 && guard < DRAIN_GUARD) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (3) @(posedge i_clk);
    endtask

    // Writes the length register; the queue is idle whenever this is called.
    task automatic write_length(input logic [CNT_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        lengths_written++;
    endtask

    // Random action with a bias towards filling (fill_pct) or draining the queue.
    function automatic t_action pick_action(input int fill_pct);
        if ($urandom_range(99) < fill_pct) begin
            return ($urandom_range(2) == 0) ? ACT_URGENT : ACT_SEND;
        end
        return ($urandom_range(3) == 0) ? ACT_PEEK : ACT_RECV;
    endfunction

    function automatic logic [MSG_WIDTH-1:0] pick_message();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return MSG_WIDTH'($urandom());
        endcase
    endfunction

    // Main sequence: reset, the scripted opening, then random phases.
    initial begin : stimulus
        int                row;
        int                phase;
        int                n;
        int                fill_pct;
        logic [CNT_W-1:0]  length_pick;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_data        <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.action     <= ACT_SEND;
        req_ch.message_in <= '0;
        steady_run        <= 1'b0;
        holds_requested   <= 0;
        mismatches        = 0;
        refused_words     = 0;
        full_hits         = 0;
        lengths_written   = 0;
        words_by_action   = '{0, 0, 0, 0};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (row = 0; row < SCRIPT_ROWS; row++) begin
            if (opening_script[row].is_cfg) begin
                settle_queue();
                write_length(opening_script[row].length);
            end else begin
                offer_word(opening_script[row].act, opening_script[row].msg,
                           opening_script[row].fixed,
                           '{opening_script[row].ok, opening_script[row].data,
                             opening_script[row].free});
            end
        end

        // Random phases. The first few pin the length extremes: one slot, a full
        // sixteen, zero taken as one, and an oversized write that saturates. The
        // fill bias flips every couple of dozen words so the queue keeps swinging
        // between full and empty and both ends wrap many times.
        for (phase = 0; phase < PHASES; phase++) begin
            settle_queue();
            case (phase)
                0:       length_pick = 5'd1;
                1:       length_pick = 5'd16;
                2:       length_pick = 5'd0;
                3:       length_pick = 5'd31;
                4:       length_pick = 5'd2;
                default: length_pick = CNT_W'($urandom_range(31));
            endcase
            write_length(length_pick);
            steady_run <= (phase == 5 || phase == 8);
            if (phase == 8) begin
                // Receiver goes quiet while the sender keeps pushing words.
                holds_requested <= holds_requested + 1;
            end
            for (n = 0; n < WORDS_PER_PHASE; n++) begin
                fill_pct = ((n / 24) % 2 == 0) ? 75 : 25;
                offer_word(pick_action(fill_pct), pick_message(), 1'b0, '0);
            end
        end

        settle_queue();
        steady_run <= 1'b0;
        if (expected_replies.size() != 0) begin
            mismatches += expected_replies.size();
            $display("%0d response words never arrived", expected_replies.size());
        end

        $display("Covered %0d words (send %0d, urgent %0d, receive %0d, peek %0d) over %0d lengths.",
                 words_by_action[0] + words_by_action[1] + words_by_action[2] +
                 words_by_action[3], words_by_action[ACT_SEND], words_by_action[ACT_URGENT],
                 words_by_action[ACT_RECV], words_by_action[ACT_PEEK], lengths_written);
        $display("%0d words refused, queue filled %0d times, %0d mismatches.",
                 refused_words, full_hits, mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
